### sv/arpt_pkg.sv
// Package for the aging prefix route table: types, codes and helper functions.
package arpt_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam logic [3:0] AGE_LIMIT_RST = 4'd3;
  localparam logic [3:0] AGE_MAX       = 4'd15;
  localparam logic [5:0] LEN_MAX       = 6'd32;

  // Command codes.
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  // Slot flags. Free must be all zeros: an unwritten slot reads as zero.
  localparam logic [1:0] FLAG_FREE     = 2'd0;
  localparam logic [1:0] FLAG_USED     = 2'd1;
  localparam logic [1:0] FLAG_DELETING = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] prefix_addr;
    logic [5:0]  prefix_len;
    logic [7:0]  plane_id;
  } arpt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  entry_index;
    logic [31:0] entry_addr;
    logic [5:0]  entry_len;
    logic [7:0]  entry_plane;
    logic [4:0]  used_count;
    logic        last;
  } arpt_out_t;

  // One word of the slot memory.
  typedef struct packed {
    logic [1:0]  flag;
    logic [3:0]  age;
    logic [31:0] addr;
    logic [5:0]  len;
    logic [7:0]  plane;
  } arpt_slot_t;

  localparam int unsigned SLOT_W = $bits(arpt_slot_t);

  function automatic logic [5:0] sat_len(input logic [5:0] len);
    return (len > LEN_MAX) ? LEN_MAX : len;
  endfunction

  // Address masked to its prefix length; a length of zero gives zero.
  function automatic logic [31:0] prefix_mask(input logic [31:0] addr,
                                              input logic [5:0] len);
    logic [5:0] sh;
    sh = LEN_MAX - len;
    if (len == 6'd0) begin
      return 32'h0;
    end
    return addr & (32'hFFFF_FFFF << sh);
  endfunction

endpackage

### sv/aging_prefix_route_table.sv
// Top level of the aging prefix route table: command sequencer over the slot RAM.
//
// Every insert, delete or dump command walks all TABLE_DEPTH slots of one slot RAM,
// one slot per cycle unless a dump result is held by the stalled output register,
// reading each slot through its single read port and writing it back in the
// following cycle when it changes. A command waits whenever one of its results
// finds the output register still stalled downstream. An unused command code is
// accepted without leaving idle and gives no result. Each finished result sits in
// an output register, so the next command is taken while it waits.
// Slot flags and ages read as free and zero until a slot is first written, so the
// block is ready right after reset. The age limit register may only be written
// while the block is idle.
module aging_prefix_route_table #(
  parameter int unsigned TABLE_DEPTH = arpt_pkg::DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  arpt_pkg::arpt_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output arpt_pkg::arpt_out_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  arpt_pkg::state_e state_q, state_d;

  logic [3:0]             age_limit_q;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;

  // Command registers.
  logic [1:0]  cmd_q;
  logic [31:0] key_q, addr_q;
  logic [5:0]  len_q;
  logic [7:0]  plane_q;

  // Scan pipeline.
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             rd_done_q, rd_done_d;
  logic             p_valid_q, p_valid_d;
  logic [IDX_W-1:0] p_idx_q, p_idx_d;

  // Per-command search results.
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic             dup_found_q, dup_found_d;
  logic [IDX_W-1:0] dup_idx_q, dup_idx_d;
  logic             age_found_q, age_found_d;
  logic [IDX_W-1:0] age_idx_q, age_idx_d;
  logic [3:0]       best_age_q, best_age_d;
  logic             del_found_q, del_found_d;
  logic [IDX_W-1:0] del_idx_q, del_idx_d;

  // Dump entry waiting to learn whether it is the final one.
  logic             pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic [31:0]      pend_addr_q, pend_addr_d;
  logic [5:0]       pend_len_q, pend_len_d;
  logic [7:0]       pend_plane_q, pend_plane_d;

  logic                out_valid_q, out_valid_d;
  arpt_pkg::arpt_out_t out_q, out_d;

  // RAM ports.
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr;
  arpt_pkg::arpt_slot_t ram_wdata, ram_rdata, p_slot;

  logic       in_xfer, out_free, p_used, p_del, p_match;
  logic       dump_emit, p_hold, p_adv, scan_end, issue;
  logic [3:0] new_age;

  arpt_ram #(
    .WIDTH(arpt_pkg::SLOT_W),
    .DEPTH(TABLE_DEPTH)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o  = (state_q != arpt_pkg::S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A slot never written reads as free with age zero.
  assign p_slot  = valid_q[p_idx_q] ? ram_rdata : '0;
  assign p_used  = p_valid_q && (p_slot.flag == arpt_pkg::FLAG_USED);
  assign p_del   = p_valid_q && (p_slot.flag == arpt_pkg::FLAG_DELETING);
  assign p_match = (arpt_pkg::prefix_mask(p_slot.addr, p_slot.len) == key_q);
  assign new_age = (p_slot.age < arpt_pkg::AGE_MAX) ? (p_slot.age + 4'd1) : arpt_pkg::AGE_MAX;

  assign dump_emit = (cmd_q == arpt_pkg::CMD_DUMP) && p_used && pend_valid_q;
  assign p_hold    = dump_emit && !out_free;
  assign p_adv     = p_valid_q && !p_hold;
  assign scan_end  = p_adv && (p_idx_q == LAST_IDX);
  assign issue     = (state_q == arpt_pkg::S_SCAN) && !rd_done_q && !p_hold;
  assign ram_re    = issue;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      arpt_pkg::S_IDLE: begin
        if (in_xfer && (in_data_i.command == arpt_pkg::CMD_INSERT ||
                        in_data_i.command == arpt_pkg::CMD_DELETE ||
                        in_data_i.command == arpt_pkg::CMD_DUMP)) begin
          state_d = arpt_pkg::S_SCAN;
        end
      end
      arpt_pkg::S_SCAN: begin
        if (scan_end) begin
          state_d = arpt_pkg::S_FINISH;
        end
      end
      arpt_pkg::S_FINISH: begin
        if (out_free) begin
          state_d = arpt_pkg::S_IDLE;
        end
      end
      default: state_d = arpt_pkg::S_IDLE;
    endcase
  end

  // Scan datapath, RAM write-back and result generation.
  always_comb begin
    logic             tgt_ok;
    logic [IDX_W-1:0] tgt_idx;

    rd_idx_d     = rd_idx_q;
    rd_done_d    = rd_done_q;
    p_valid_d    = p_valid_q;
    p_idx_d      = p_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    dup_found_d  = dup_found_q;
    dup_idx_d    = dup_idx_q;
    age_found_d  = age_found_q;
    age_idx_d    = age_idx_q;
    best_age_d   = best_age_q;
    del_found_d  = del_found_q;
    del_idx_d    = del_idx_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    pend_addr_d  = pend_addr_q;
    pend_len_d   = pend_len_q;
    pend_plane_d = pend_plane_q;
    count_d      = count_q;
    valid_d      = valid_q;
    ram_we       = 1'b0;
    ram_waddr    = p_idx_q;
    ram_wdata    = p_slot;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    tgt_ok       = free_found_q || age_found_q;
    tgt_idx      = free_found_q ? free_idx_q : age_idx_q;

    if (in_xfer) begin
      rd_idx_d     = '0;
      rd_done_d    = 1'b0;
      p_valid_d    = 1'b0;
      free_found_d = 1'b0;
      dup_found_d  = 1'b0;
      age_found_d  = 1'b0;
      best_age_d   = 4'd0;
      del_found_d  = 1'b0;
      pend_valid_d = 1'b0;
    end

    if (issue) begin
      p_valid_d = 1'b1;
      p_idx_d   = rd_idx_q;
      if (rd_idx_q == LAST_IDX) begin
        rd_done_d = 1'b1;
      end else begin
        rd_idx_d = rd_idx_q + IDX_W'(1);
      end
    end else if (p_adv) begin
      p_valid_d = 1'b0;
    end

    if (p_adv) begin
      unique case (cmd_q)
        arpt_pkg::CMD_INSERT: begin
          if (p_valid_q && p_slot.flag == arpt_pkg::FLAG_FREE && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = p_idx_q;
          end
          if (p_used && !dup_found_q && p_match) begin
            dup_found_d = 1'b1;
            dup_idx_d   = p_idx_q;
          end
          if (p_del) begin
            ram_we        = 1'b1;
            ram_wdata.age = new_age;
            ram_wdata.flag = (new_age >= age_limit_q) ? arpt_pkg::FLAG_FREE
                                                       : arpt_pkg::FLAG_DELETING;
            if (new_age > best_age_q) begin
              best_age_d  = new_age;
              age_found_d = 1'b1;
              age_idx_d   = p_idx_q;
            end
          end
        end
        arpt_pkg::CMD_DELETE: begin
          if (p_used && p_match && !del_found_q) begin
            del_found_d    = 1'b1;
            del_idx_d      = p_idx_q;
            ram_we         = 1'b1;
            ram_wdata.flag = arpt_pkg::FLAG_DELETING;
            ram_wdata.age  = 4'd0;
          end
        end
        arpt_pkg::CMD_DUMP: begin
          if (dump_emit) begin
            out_valid_d       = 1'b1;
            out_d             = '0;
            out_d.status      = arpt_pkg::ST_DONE;
            out_d.entry_index = 4'(pend_idx_q);
            out_d.entry_addr  = pend_addr_q;
            out_d.entry_len   = pend_len_q;
            out_d.entry_plane = pend_plane_q;
            out_d.used_count  = 5'(count_q);
            out_d.last        = 1'b0;
          end
          if (p_used) begin
            pend_valid_d = 1'b1;
            pend_idx_d   = p_idx_q;
            pend_addr_d  = p_slot.addr;
            pend_len_d   = p_slot.len;
            pend_plane_d = p_slot.plane;
          end
        end
        default: begin
        end
      endcase
    end

    if (state_q == arpt_pkg::S_FINISH && out_free) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      out_d.last  = 1'b1;
      unique case (cmd_q)
        arpt_pkg::CMD_INSERT: begin
          if (dup_found_q) begin
            out_d.status      = arpt_pkg::ST_DUP;
            out_d.entry_index = 4'(dup_idx_q);
          end else if (tgt_ok) begin
            ram_we            = 1'b1;
            ram_waddr         = tgt_idx;
            ram_wdata.flag    = arpt_pkg::FLAG_USED;
            ram_wdata.age     = 4'd0;
            ram_wdata.addr    = addr_q;
            ram_wdata.len     = len_q;
            ram_wdata.plane   = plane_q;
            count_d           = count_q + CNT_W'(1);
            out_d.status      = arpt_pkg::ST_DONE;
            out_d.entry_index = 4'(tgt_idx);
          end else begin
            out_d.status = arpt_pkg::ST_FULL;
          end
        end
        arpt_pkg::CMD_DELETE: begin
          if (del_found_q) begin
            if (count_q != '0) begin
              count_d = count_q - CNT_W'(1);
            end
            out_d.status      = arpt_pkg::ST_DONE;
            out_d.entry_index = 4'(del_idx_q);
          end else begin
            out_d.status = arpt_pkg::ST_NOT_FOUND;
          end
        end
        arpt_pkg::CMD_DUMP: begin
          if (pend_valid_q) begin
            out_d.status      = arpt_pkg::ST_DONE;
            out_d.entry_index = 4'(pend_idx_q);
            out_d.entry_addr  = pend_addr_q;
            out_d.entry_len   = pend_len_q;
            out_d.entry_plane = pend_plane_q;
          end else begin
            out_d.status = arpt_pkg::ST_EMPTY;
          end
        end
        default: begin
        end
      endcase
      out_d.used_count = 5'(count_d);
    end

    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= arpt_pkg::S_IDLE;
      age_limit_q  <= arpt_pkg::AGE_LIMIT_RST;
      count_q      <= '0;
      valid_q      <= '0;
      rd_done_q    <= 1'b1;
      p_valid_q    <= 1'b0;
      free_found_q <= 1'b0;
      dup_found_q  <= 1'b0;
      age_found_q  <= 1'b0;
      del_found_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      if (cfg_we_i) begin
        age_limit_q <= cfg_data_i;
      end
      count_q      <= count_d;
      valid_q      <= valid_d;
      rd_done_q    <= rd_done_d;
      p_valid_q    <= p_valid_d;
      free_found_q <= free_found_d;
      dup_found_q  <= dup_found_d;
      age_found_q  <= age_found_d;
      del_found_q  <= del_found_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q   <= in_data_i.command;
      addr_q  <= in_data_i.prefix_addr;
      len_q   <= arpt_pkg::sat_len(in_data_i.prefix_len);
      plane_q <= in_data_i.plane_id;
      key_q   <= arpt_pkg::prefix_mask(in_data_i.prefix_addr,
                                       arpt_pkg::sat_len(in_data_i.prefix_len));
    end
    rd_idx_q     <= rd_idx_d;
    p_idx_q      <= p_idx_d;
    free_idx_q   <= free_idx_d;
    dup_idx_q    <= dup_idx_d;
    age_idx_q    <= age_idx_d;
    best_age_q   <= best_age_d;
    del_idx_q    <= del_idx_d;
    pend_idx_q   <= pend_idx_d;
    pend_addr_q  <= pend_addr_d;
    pend_len_q   <= pend_len_d;
    pend_plane_q <= pend_plane_d;
    out_q        <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("active count exceeds table depth");

  a_finish_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == arpt_pkg::S_FINISH && out_free) |=> out_valid_o)
    else $error("finished command produced no result");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == arpt_pkg::S_IDLE) |-> (!p_valid_q && !ram_we))
    else $error("slot pipeline active while idle");

  a_hold_keeps_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_hold |=> (p_valid_q && $stable(p_idx_q) && $stable(ram_rdata)))
    else $error("held dump slot changed under a stalled transfer");
`endif

endmodule

### sv/arpt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module arpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
